>>> hdl/lcp_pkg.sv
// Shared types and constants for the LFU put cache.
// Used by lcp_cell and lfu_cache_put; depends on nothing else.
`default_nettype none

package lcp_pkg;

   localparam int KEY_BITS       = 64;
   localparam int VALUE_BITS     = 64;
   localparam int HIT_BITS       = 32;
   localparam int REQ_TDATA_BITS = 128;
   localparam int RSP_TDATA_BITS = 168;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   // what the update cycle does to the chain
   typedef enum logic [1:0] {
      KIND_HIT,
      KIND_FILL,
      KIND_EVICT
   } kind_type;

   // search flags carried cell to cell
   typedef struct packed {
      logic match_found;
      logic free_found;
   } acc_flags_type;

   // update command broadcast to every cell
   typedef struct packed {
      logic     do_update;
      kind_type kind;
   } upd_type;

endpackage

`default_nettype wire

>>> hdl/lcp_cell.sv
// One cache slot of the LFU chain plus its stage of the search accumulator.
// Depends on lcp_pkg.
`default_nettype none

module lcp_cell #(
   parameter int IDX_BITS   = 3,
   parameter int COUNT_BITS = 16,
   parameter int CELL_INDEX = 0
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [lcp_pkg::KEY_BITS-1:0]    search_key,
   input  wire logic [lcp_pkg::VALUE_BITS-1:0]  upd_value,
   input  wire lcp_pkg::upd_type                upd,
   input  wire logic [IDX_BITS-1:0]             upd_target,
   input  wire logic [IDX_BITS-1:0]             upd_old_rank,
   // accumulator from the previous cell
   input  wire lcp_pkg::acc_flags_type          acc_flags_in,
   input  wire logic [IDX_BITS-1:0]             match_idx_in,
   input  wire logic [IDX_BITS-1:0]             match_rank_in,
   input  wire logic [IDX_BITS-1:0]             free_idx_in,
   input  wire logic [IDX_BITS-1:0]             best_idx_in,
   input  wire logic [IDX_BITS-1:0]             best_rank_in,
   input  wire logic [COUNT_BITS-1:0]           best_count_in,
   input  wire logic [lcp_pkg::KEY_BITS-1:0]    best_key_in,
   input  wire logic [lcp_pkg::VALUE_BITS-1:0]  best_value_in,
   // registered accumulator to the next cell
   output lcp_pkg::acc_flags_type               acc_flags_out,
   output logic [IDX_BITS-1:0]                  match_idx_out,
   output logic [IDX_BITS-1:0]                  match_rank_out,
   output logic [IDX_BITS-1:0]                  free_idx_out,
   output logic [IDX_BITS-1:0]                  best_idx_out,
   output logic [IDX_BITS-1:0]                  best_rank_out,
   output logic [COUNT_BITS-1:0]                best_count_out,
   output logic [lcp_pkg::KEY_BITS-1:0]         best_key_out,
   output logic [lcp_pkg::VALUE_BITS-1:0]       best_value_out
);

   localparam logic [IDX_BITS-1:0] MY_INDEX = IDX_BITS'(CELL_INDEX);
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // slot state
   logic                              valid_ff;
   logic                              valid_in;
   logic [lcp_pkg::KEY_BITS-1:0]      key_ff, key_in;
   logic [lcp_pkg::VALUE_BITS-1:0]    value_ff, value_in;
   logic [COUNT_BITS-1:0]             count_ff, count_in;
   logic [IDX_BITS-1:0]               rank_ff, rank_in;

   // accumulator stage
   lcp_pkg::acc_flags_type            acc_flags_ff, acc_flags_in_nxt;
   logic [IDX_BITS-1:0]               match_idx_ff, match_idx_in_nxt;
   logic [IDX_BITS-1:0]               match_rank_ff, match_rank_in_nxt;
   logic [IDX_BITS-1:0]               free_idx_ff, free_idx_in_nxt;
   logic [IDX_BITS-1:0]               best_idx_ff, best_idx_in_nxt;
   logic [IDX_BITS-1:0]               best_rank_ff, best_rank_in_nxt;
   logic [COUNT_BITS-1:0]             best_count_ff, best_count_in_nxt;
   logic [lcp_pkg::KEY_BITS-1:0]      best_key_ff, best_key_in_nxt;
   logic [lcp_pkg::VALUE_BITS-1:0]    best_value_ff, best_value_in_nxt;

   logic self_match;
   logic take_self;
   logic is_target;

   always_comb begin
      self_match = valid_ff && (key_ff == search_key);
      // first cell seeds the eviction candidate with itself
      take_self  = (CELL_INDEX == 0) || (count_ff < best_count_in) ||
                   ((count_ff == best_count_in) && (rank_ff > best_rank_in));

      acc_flags_in_nxt  = acc_flags_in;
      match_idx_in_nxt  = match_idx_in;
      match_rank_in_nxt = match_rank_in;
      free_idx_in_nxt   = free_idx_in;
      if (!acc_flags_in.match_found && self_match) begin
         acc_flags_in_nxt.match_found = 1'b1;
         match_idx_in_nxt             = MY_INDEX;
         match_rank_in_nxt            = rank_ff;
      end
      if (!acc_flags_in.free_found && !valid_ff) begin
         acc_flags_in_nxt.free_found = 1'b1;
         free_idx_in_nxt             = MY_INDEX;
      end

      if (take_self) begin
         best_idx_in_nxt   = MY_INDEX;
         best_rank_in_nxt  = rank_ff;
         best_count_in_nxt = count_ff;
         best_key_in_nxt   = key_ff;
         best_value_in_nxt = value_ff;
      end else begin
         best_idx_in_nxt   = best_idx_in;
         best_rank_in_nxt  = best_rank_in;
         best_count_in_nxt = best_count_in;
         best_key_in_nxt   = best_key_in;
         best_value_in_nxt = best_value_in;
      end
   end

   always_comb begin
      is_target = (upd_target == MY_INDEX);
      valid_in  = valid_ff;
      key_in    = key_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      rank_in   = rank_ff;
      if (upd.do_update) begin
         if (is_target) begin
            valid_in = 1'b1;
            key_in   = search_key;
            value_in = upd_value;
            rank_in  = '0;
            if (upd.kind == lcp_pkg::KIND_HIT) begin
               count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_ONE;
            end else begin
               count_in = COUNT_ONE;
            end
         end else if (valid_ff &&
                      ((upd.kind == lcp_pkg::KIND_FILL) || (rank_ff < upd_old_rank))) begin
            // entries newer than the touched one age by one
            rank_in = rank_ff + IDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      value_ff       <= value_in;
      count_ff       <= count_in;
      rank_ff        <= rank_in;
      acc_flags_ff   <= acc_flags_in_nxt;
      match_idx_ff   <= match_idx_in_nxt;
      match_rank_ff  <= match_rank_in_nxt;
      free_idx_ff    <= free_idx_in_nxt;
      best_idx_ff    <= best_idx_in_nxt;
      best_rank_ff   <= best_rank_in_nxt;
      best_count_ff  <= best_count_in_nxt;
      best_key_ff    <= best_key_in_nxt;
      best_value_ff  <= best_value_in_nxt;
   end

   assign acc_flags_out  = acc_flags_ff;
   assign match_idx_out  = match_idx_ff;
   assign match_rank_out = match_rank_ff;
   assign free_idx_out   = free_idx_ff;
   assign best_idx_out   = best_idx_ff;
   assign best_rank_out  = best_rank_ff;
   assign best_count_out = best_count_ff;
   assign best_key_out   = best_key_ff;
   assign best_value_out = best_value_ff;

endmodule

`default_nettype wire

>>> hdl/lfu_cache_put.sv
// LFU put cache, top level: controller, result register and the row of cells.
// Depends on lcp_pkg and lcp_cell.
//
// Fully associative LFU cache taking put items (key, value). Each item returns one
// result: hit, evicted, victim key/value (zero unless evicted) and a saturating hit
// total. Every slot is a cell in a chain; the search for a match, a free slot and the
// eviction victim (lowest use count, least recent among ties) moves one cell per
// cycle, after which a single update writes all cells at once. A new item is taken
// only after the previous one has rippled through the whole chain and its update
// has fired; the update waits while a previous result has not been taken. No
// clearing pass follows reset.
`default_nettype none

module lfu_cache_put #(
   parameter int ENTRIES    = 8,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [63:0] key, [127:64] value
   input  wire logic [lcp_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] hit, [1] evicted, [65:2] victim_key, [129:66] victim_value,
   // [161:130] hits_so_far, [167:162] zero
   output logic [lcp_pkg::RSP_TDATA_BITS-1:0]       rsp_tdata
);

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_BITS-1:0] LAST_STEP = IDX_BITS'(ENTRIES - 1);
   localparam int RSP_USED = 2 + lcp_pkg::KEY_BITS + lcp_pkg::VALUE_BITS + lcp_pkg::HIT_BITS;
   localparam int RSP_PAD  = lcp_pkg::RSP_TDATA_BITS - RSP_USED;
   localparam logic [lcp_pkg::HIT_BITS-1:0] HIT_MAX = '1;

   lcp_pkg::state_type state_ff, state_in;
   logic [IDX_BITS-1:0] step_ff, step_in;

   logic [lcp_pkg::KEY_BITS-1:0]   key_ff, key_in;
   logic [lcp_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic [lcp_pkg::HIT_BITS-1:0]   hit_total_ff, hit_total_in;

   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic                            rsp_hit_ff, rsp_hit_in;
   logic                            rsp_evicted_ff, rsp_evicted_in;
   logic [lcp_pkg::KEY_BITS-1:0]    rsp_vkey_ff, rsp_vkey_in;
   logic [lcp_pkg::VALUE_BITS-1:0]  rsp_vval_ff, rsp_vval_in;
   logic [lcp_pkg::HIT_BITS-1:0]    rsp_hits_ff, rsp_hits_in;

   logic req_accept;
   logic out_free;
   logic upd_fire;

   lcp_pkg::upd_type    upd;
   logic [IDX_BITS-1:0] upd_target;
   logic [IDX_BITS-1:0] upd_old_rank;

   // accumulator chain; element 0 feeds the first cell
   lcp_pkg::acc_flags_type          acc_flags  [ENTRIES+1];
   logic [IDX_BITS-1:0]             match_idx  [ENTRIES+1];
   logic [IDX_BITS-1:0]             match_rank [ENTRIES+1];
   logic [IDX_BITS-1:0]             free_idx   [ENTRIES+1];
   logic [IDX_BITS-1:0]             best_idx   [ENTRIES+1];
   logic [IDX_BITS-1:0]             best_rank  [ENTRIES+1];
   logic [COUNT_BITS-1:0]           best_count [ENTRIES+1];
   logic [lcp_pkg::KEY_BITS-1:0]    best_key   [ENTRIES+1];
   logic [lcp_pkg::VALUE_BITS-1:0]  best_value [ENTRIES+1];

   assign acc_flags[0]  = '0;
   assign match_idx[0]  = '0;
   assign match_rank[0] = '0;
   assign free_idx[0]   = '0;
   assign best_idx[0]   = '0;
   assign best_rank[0]  = '0;
   assign best_count[0] = '0;
   assign best_key[0]   = '0;
   assign best_value[0] = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lcp_cell #(
         .IDX_BITS   (IDX_BITS),
         .COUNT_BITS (COUNT_BITS),
         .CELL_INDEX (g)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .search_key     (key_ff),
         .upd_value      (value_ff),
         .upd            (upd),
         .upd_target     (upd_target),
         .upd_old_rank   (upd_old_rank),
         .acc_flags_in   (acc_flags[g]),
         .match_idx_in   (match_idx[g]),
         .match_rank_in  (match_rank[g]),
         .free_idx_in    (free_idx[g]),
         .best_idx_in    (best_idx[g]),
         .best_rank_in   (best_rank[g]),
         .best_count_in  (best_count[g]),
         .best_key_in    (best_key[g]),
         .best_value_in  (best_value[g]),
         .acc_flags_out  (acc_flags[g+1]),
         .match_idx_out  (match_idx[g+1]),
         .match_rank_out (match_rank[g+1]),
         .free_idx_out   (free_idx[g+1]),
         .best_idx_out   (best_idx[g+1]),
         .best_rank_out  (best_rank[g+1]),
         .best_count_out (best_count[g+1]),
         .best_key_out   (best_key[g+1]),
         .best_value_out (best_value[g+1])
      );
   end

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcp_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = lcp_pkg::ST_SEARCH;
         end
         lcp_pkg::ST_SEARCH: begin
            if (step_ff == LAST_STEP) state_in = lcp_pkg::ST_UPDATE;
         end
         lcp_pkg::ST_UPDATE: begin
            if (out_free) state_in = lcp_pkg::ST_IDLE;
         end
         default: state_in = lcp_pkg::ST_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      req_tready = 1'b0;
      step_in    = '0;
      upd_fire   = 1'b0;
      unique case (state_ff)
         lcp_pkg::ST_IDLE:   req_tready = 1'b1;
         lcp_pkg::ST_SEARCH: step_in    = step_ff + IDX_BITS'(1);
         lcp_pkg::ST_UPDATE: upd_fire   = out_free;
         default:            req_tready = 1'b0;
      endcase
   end

   // decision from the end of the chain
   always_comb begin
      upd.do_update = upd_fire;
      priority if (acc_flags[ENTRIES].match_found) begin
         upd.kind     = lcp_pkg::KIND_HIT;
         upd_target   = match_idx[ENTRIES];
         upd_old_rank = match_rank[ENTRIES];
      end else if (acc_flags[ENTRIES].free_found) begin
         upd.kind     = lcp_pkg::KIND_FILL;
         upd_target   = free_idx[ENTRIES];
         upd_old_rank = '0;
      end else begin
         upd.kind     = lcp_pkg::KIND_EVICT;
         upd_target   = best_idx[ENTRIES];
         upd_old_rank = best_rank[ENTRIES];
      end
   end

   always_comb begin
      key_in         = req_accept ? req_tdata[63:0] : key_ff;
      value_in       = req_accept ? req_tdata[127:64] : value_ff;
      hit_total_in   = hit_total_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_vkey_in    = rsp_vkey_ff;
      rsp_vval_in    = rsp_vval_ff;
      rsp_hits_in    = rsp_hits_ff;
      if (upd.do_update) begin
         if ((upd.kind == lcp_pkg::KIND_HIT) && (hit_total_ff != HIT_MAX)) begin
            hit_total_in = hit_total_ff + lcp_pkg::HIT_BITS'(1);
         end
         rsp_tvalid_in  = 1'b1;
         rsp_hit_in     = (upd.kind == lcp_pkg::KIND_HIT);
         rsp_evicted_in = (upd.kind == lcp_pkg::KIND_EVICT);
         rsp_vkey_in    = (upd.kind == lcp_pkg::KIND_EVICT) ? best_key[ENTRIES] : '0;
         rsp_vval_in    = (upd.kind == lcp_pkg::KIND_EVICT) ? best_value[ENTRIES] : '0;
         rsp_hits_in    = hit_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lcp_pkg::ST_IDLE;
         step_ff       <= '0;
         hit_total_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         hit_total_ff  <= hit_total_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      value_ff       <= value_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_vkey_ff    <= rsp_vkey_in;
      rsp_vval_ff    <= rsp_vval_in;
      rsp_hits_ff    <= rsp_hits_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_hits_ff, rsp_vval_ff, rsp_vkey_ff,
                        rsp_evicted_ff, rsp_hit_ff};

`ifndef NO_ASSERTIONS
   a_accept_starts_search: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == lcp_pkg::ST_SEARCH))
      else $error("accepted item did not start a search");

   a_update_gives_result: assert property (@(posedge clock) disable iff (reset)
      upd.do_update |=> (rsp_tvalid_ff && (state_ff == lcp_pkg::ST_IDLE)))
      else $error("update did not load a result");

   a_hit_excludes_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> !(rsp_hit_ff && rsp_evicted_ff))
      else $error("result is both hit and eviction");

   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_evicted_ff) |-> ((rsp_vkey_ff == '0) && (rsp_vval_ff == '0)))
      else $error("victim fields set without eviction");

   a_hit_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (hit_total_ff >= $past(hit_total_ff)))
      else $error("hit total decreased");
`endif

endmodule

`default_nettype wire

>>> sim/tb_lfu_cache_put.sv
// Self-checking testbench for lfu_cache_put: directed put table, then random puts over
// a small key pool with bursts, receiver stalls and one long receiver hold-off.
// Depends on lcp_pkg and the lfu_cache_put RTL.

module tb_lfu_cache_put;

   localparam int SLOTS        = 8;
   localparam int USE_BITS     = 16;
   localparam int RANDOM_ITEMS = 1630;
   localparam int POOL_SIZE    = 16;

   // lowest field in the lowest bits, as on rsp_tdata
   typedef struct packed {
      logic [lcp_pkg::HIT_BITS-1:0]   hits_so_far;
      logic [lcp_pkg::VALUE_BITS-1:0] victim_value;
      logic [lcp_pkg::KEY_BITS-1:0]   victim_key;
      logic                           evicted;
      logic                           hit;
   } put_result_type;

   typedef struct packed {
      logic [lcp_pkg::KEY_BITS-1:0]   key;
      logic [lcp_pkg::VALUE_BITS-1:0] value;
      logic                           pinned;
      put_result_type                 result;
   } put_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [lcp_pkg::REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [lcp_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;

   // predictor's copy of the cache
   logic                           cache_valid [SLOTS] = '{default: 1'b0};
   logic [lcp_pkg::KEY_BITS-1:0]   cache_key   [SLOTS];
   logic [lcp_pkg::VALUE_BITS-1:0] cache_value [SLOTS];
   logic [USE_BITS-1:0]            cache_uses  [SLOTS];
   logic [2:0]                     cache_age   [SLOTS];
   logic [lcp_pkg::HIT_BITS-1:0]   hit_count = '0;

   put_result_type pending_results[$];
   put_row_type    put_rows[$];
   int             mismatches = 0;

   // directed rows may pin the result the block must return
   logic           pin_valid = 1'b0;
   put_result_type pin_result = '0;

   logic hold_rsp = 1'b0;     // one long receiver hold-off

   lfu_cache_put #(
      .ENTRIES   (SLOTS),
      .COUNT_BITS(USE_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #2 clock = ~clock;

   // slot becomes most recent; valid slots more recent than old_age grow older
   function automatic void promote(int slot, int old_age);
      for (int i = 0; i < SLOTS; i++) begin
         if (i != slot && cache_valid[i] && int'(cache_age[i]) < old_age)
            cache_age[i] = cache_age[i] + 3'd1;
      end
      cache_age[slot] = '0;
   endfunction

   function automatic put_result_type predict_put(logic [lcp_pkg::KEY_BITS-1:0] key,
                                                  logic [lcp_pkg::VALUE_BITS-1:0] value);
      put_result_type r;
      int match;
      int vacant;
      int slot;
      r = '0;
      match = -1;
      vacant = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (cache_valid[i]) begin
            if (match < 0 && cache_key[i] == key) match = i;
         end else if (vacant < 0) begin
            vacant = i;
         end
      end
      if (match >= 0) begin
         r.hit = 1'b1;
         if (hit_count != '1) hit_count = hit_count + lcp_pkg::HIT_BITS'(1);
         cache_value[match] = value;
         if (cache_uses[match] != '1) cache_uses[match] = cache_uses[match] + USE_BITS'(1);
         promote(match, int'(cache_age[match]));
      end else begin
         if (vacant >= 0) begin
            slot = vacant;
            cache_valid[slot] = 1'b1;
            promote(slot, SLOTS);
         end else begin
            // lowest use count, least recently touched among ties
            slot = 0;
            for (int i = 1; i < SLOTS; i++) begin
               if (cache_uses[i] < cache_uses[slot] ||
                   (cache_uses[i] == cache_uses[slot] && cache_age[i] > cache_age[slot]))
                  slot = i;
            end
            r.evicted      = 1'b1;
            r.victim_key   = cache_key[slot];
            r.victim_value = cache_value[slot];
            promote(slot, int'(cache_age[slot]));
         end
         cache_key[slot]   = key;
         cache_value[slot] = value;
         cache_uses[slot]  = USE_BITS'(1);
      end
      r.hits_so_far = hit_count;
      return r;
   endfunction

   task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
      $display("%0t mismatch on %s: expected %h, actual %h", $time, what, want, got);
      mismatches++;
   endtask

   // accepted items feed the predictor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         put_result_type want;
         want = predict_put(req_tdata[lcp_pkg::KEY_BITS-1:0],
                            req_tdata[lcp_pkg::REQ_TDATA_BITS-1:lcp_pkg::KEY_BITS]);
         if (pin_valid) want = pin_result;
         pending_results.push_back(want);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         put_result_type want;
         put_result_type got;
         got = put_result_type'(rsp_tdata[$bits(put_result_type)-1:0]);
         if (pending_results.size() == 0) begin
            $display("%0t result with nothing expected: %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (got.hit !== want.hit) flag_mismatch("hit", 64'(want.hit), 64'(got.hit));
            if (got.evicted !== want.evicted)
               flag_mismatch("evicted", 64'(want.evicted), 64'(got.evicted));
            if (got.victim_key !== want.victim_key)
               flag_mismatch("victim_key", want.victim_key, got.victim_key);
            if (got.victim_value !== want.victim_value)
               flag_mismatch("victim_value", want.victim_value, got.victim_value);
            if (got.hits_so_far !== want.hits_so_far)
               flag_mismatch("hits_so_far", 64'(want.hits_so_far), 64'(got.hits_so_far));
            if (rsp_tdata[lcp_pkg::RSP_TDATA_BITS-1:$bits(put_result_type)] !== '0)
               flag_mismatch("padding", 64'(0),
                  64'(rsp_tdata[lcp_pkg::RSP_TDATA_BITS-1:$bits(put_result_type)]));
         end
      end
   end

   // receiver: stall rate changes every stretch, with one long hold-off
   initial begin
      int stall_pct;
      int stretch_left;
      bit hold_taken;
      stall_pct = 0;
      stretch_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(40, 200);
               case ($urandom_range(3))
                  0: stall_pct = 0;
                  1: stall_pct = 25;
                  2: stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            stretch_left--;
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_put(logic [lcp_pkg::KEY_BITS-1:0] key,
                           logic [lcp_pkg::VALUE_BITS-1:0] value);
      req_tdata  <= {value, key};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic idle_for(int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom, $urandom, $urandom};
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic row(logic [63:0] key, logic [63:0] value, logic pinned,
                      logic hit, logic evicted, logic [63:0] vkey, logic [63:0] vval,
                      logic [31:0] hits);
      put_rows.push_back('{key, value, pinned, '{hits, vval, vkey, evicted, hit}});
   endtask

   initial begin
      logic [63:0] key_pool [POOL_SIZE];
      logic [63:0] k;
      logic [63:0] ks [6];
      int sent;
      int burst;
      int span;
      int pick;

      ks[0] = 64'h0000_0000_0000_0001;
      ks[1] = 64'h8000_0000_0000_0000;
      ks[2] = 64'h5555_5555_5555_5555;
      ks[3] = 64'hAAAA_AAAA_AAAA_AAAA;
      ks[4] = 64'h0123_4567_89AB_CDEF;
      ks[5] = 64'hFEDC_BA98_7654_3210;

      row('0, '0, 1'b1, 1'b0, 1'b0, '0, '0, 32'd0);
      row('1, '1, 1'b1, 1'b0, 1'b0, '0, '0, 32'd0);
      row('0, '1, 1'b1, 1'b1, 1'b0, '0, '0, 32'd1);
      row('1, '0, 1'b1, 1'b1, 1'b0, '0, '0, 32'd2);
      for (int i = 0; i < 6; i++) row(ks[i], ~ks[i], 1'b1, 1'b0, 1'b0, '0, '0, 32'd2);
      // full: oldest of the count-one entries goes
      row(64'h0000_0000_FFFF_FFFF, 64'h1111_2222_3333_4444, 1'b1, 1'b0, 1'b1,
          ks[0], ~ks[0], 32'd2);
      row(ks[2], 64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 1'b1, 1'b0, '0, '0, 32'd3);
      row(64'hFFFF_FFFF_0000_0000, 64'h9999_8888_7777_6666, 1'b1, 1'b0, 1'b1,
          ks[1], ~ks[1], 32'd3);
      row(ks[0], 64'h0000_0000_0000_00FF, 1'b0, 1'b0, 1'b0, '0, '0, 32'd0);
      row(ks[4], 64'h1234_5678_9ABC_DEF0, 1'b0, 1'b0, 1'b0, '0, '0, 32'd0);
      row(ks[5], 64'hFFFF_0000_FFFF_0000, 1'b0, 1'b0, 1'b0, '0, '0, 32'd0);
      row(64'h0000_0000_FFFF_FFFF, 64'h2, 1'b0, 1'b0, 1'b0, '0, '0, 32'd0);
      row(64'hDEAD_BEEF_CAFE_F00D, 64'h3, 1'b0, 1'b0, 1'b0, '0, '0, 32'd0);
      row(ks[3] ^ 64'h1, 64'h4, 1'b0, 1'b0, 1'b0, '0, '0, 32'd0);
      row('0, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b0, '0, '0, 32'd0);
      row('1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0, '0, '0, 32'd0);

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (put_rows[i]) begin
         pin_valid  = put_rows[i].pinned;
         pin_result = put_rows[i].result;
         send_put(put_rows[i].key, put_rows[i].value);
         if ($urandom_range(2) == 0) idle_for($urandom_range(1, 4));
      end
      pin_valid = 1'b0;

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[3] = key_pool[2] ^ 64'h8000_0000_0000_0000;

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         span  = $urandom_range(5, POOL_SIZE);
         for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
            pick = $urandom_range(99);
            if (pick < 75) k = key_pool[$urandom_range(span - 1)];
            else if (pick < 85)
               k = key_pool[$urandom_range(span - 1)] ^ (64'h1 << $urandom_range(63));
            else k = {$urandom, $urandom};
            send_put(k, {$urandom, $urandom});
            sent++;
            if (sent == 400) hold_rsp = 1'b1;
            if (sent == 900) begin
               idle_for(1);
               while (pending_results.size() != 0) @(negedge clock);
            end
         end
         if ($urandom_range(3) != 0) idle_for($urandom_range(1, 8));
      end

      idle_for(1);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(4 * 3_000_000);
      $display("FAIL");
      $finish;
   end

endmodule

>>> filelist.f
hdl/lcp_pkg.sv
hdl/lcp_cell.sv
hdl/lfu_cache_put.sv
sim/tb_lfu_cache_put.sv
